@@ sv/gcfa_pkg.sv @@
// Shared types, constants and constant tables for the gamma-correct frame averager.
// Holds the linearising and gamma-encoding tables, which are built at elaboration.
// No dependencies.
package gcfa_pkg;

    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned CH_W    = 15;
    localparam int unsigned LIN_W   = 10;
    localparam int unsigned GAM_W   = 8;

    localparam int unsigned DEF_PIXELS = 1048576;
    localparam int unsigned DEF_FRAMES = 20;

    localparam logic [CH_W-1:0]  CH_MAX  = 15'd32767;
    localparam logic [LIN_W-1:0] LIN_MAX = 10'd1023;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef logic [CH_W-1:0] t_ch_sum;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_ch_sum red;
        t_ch_sum green;
        t_ch_sum blue;
    } t_sum3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_sum3             sum;
    } t_sum_item;

    typedef logic [255:0][LIN_W-1:0]  t_lin_table;
    typedef logic [1023:0][GAM_W-1:0] t_gam_table;

    // a^ea * b^eb, wide enough for every comparison below.
    function automatic logic [159:0] big_term(input int unsigned a, input int unsigned ea,
                                              input int unsigned b, input int unsigned eb);
        logic [159:0] r;
        r = 160'd1;
        for (int i = 0; i < ea; i++) r = r * 160'(a);
        for (int i = 0; i < eb; i++) r = r * 160'(b);
        return r;
    endfunction

    // Largest k with k^5 * 255^11 <= j^11 * 1023^5.
    function automatic logic [LIN_W-1:0] lin_entry(input int unsigned j);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 1023;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (big_term(mid, 5, 255, 11) <= big_term(j, 11, 1023, 5)) lo = mid;
            else hi = mid - 1;
        end
        return LIN_W'(lo);
    endfunction

    // Largest k with k^11 * 1023^5 <= j^5 * 255^11.
    function automatic logic [GAM_W-1:0] gam_entry(input int unsigned j);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (big_term(mid, 11, 1023, 5) <= big_term(j, 5, 255, 11)) lo = mid;
            else hi = mid - 1;
        end
        return GAM_W'(lo);
    endfunction

    function automatic t_lin_table build_lin_table();
        t_lin_table t;
        for (int j = 0; j < 256; j++) t[j] = lin_entry(j);
        return t;
    endfunction

    function automatic t_gam_table build_gam_table();
        t_gam_table t;
        for (int j = 0; j < 1024; j++) t[j] = gam_entry(j);
        return t;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();
    localparam t_gam_table GAM_TABLE = build_gam_table();

endpackage

@@ sv/gamma_correct_frame_averager_core.sv @@
// The block takes one request per clock cycle unless stalled, palette writes and pixels
// alike, and an averaged pixel leaves the output register after passing the accumulate,
// sum and quotient registers. Throughput is set by the accumulator memory, which has one
// read and one write port: a pixel is read when its request is accepted and written back
// when it leaves the accumulate stage, so a request for the same pixel accepted in that
// same cycle takes the written value from a forwarding register. When the output is held
// off, three averaged pixels wait inside and the next last-frame request stalls the input
// until one is taken. Depends on gcfa_pkg, gcfa_palette, gcfa_accum and gcfa_encode.
module gamma_correct_frame_averager_core
    import gcfa_pkg::*;
#(
    parameter int unsigned PIXELS = DEF_PIXELS,
    parameter int unsigned FRAMES = DEF_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // color_index[7:0], red[15:8], green[23:16], blue[31:24], pixel_address[51:32],
    // first_frame[52], last_frame[53], zero padding[55:54].
    input  logic [55:0] s_axis_tdata,
    // kind[0].
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_address[19:0], out_red[27:20], out_green[35:28], out_blue[43:36],
    // zero padding[47:44].
    output logic [47:0] m_axis_tdata
);

    logic              take;
    logic              kind;
    logic [COLOR_W-1:0] color_index;
    t_rgb              wr_rgb;
    t_rgb              pal_rgb;
    logic              sum_valid;
    logic              sum_ready;
    t_sum_item         sum_item;
    logic [ADDR_W-1:0] out_addr;
    t_rgb              out_rgb;

    assign kind         = s_axis_tuser[0];
    assign color_index  = s_axis_tdata[7:0];
    assign wr_rgb.red   = s_axis_tdata[15:8];
    assign wr_rgb.green = s_axis_tdata[23:16];
    assign wr_rgb.blue  = s_axis_tdata[31:24];
    assign take         = s_axis_tvalid && s_axis_tready;

    gcfa_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (take && (kind == KIND_PALETTE)),
        .i_waddr (color_index),
        .i_wdata (wr_rgb),
        .i_re    (take),
        .i_raddr (color_index),
        .o_rdata (pal_rgb)
    );

    gcfa_accum #(
        .PIXELS (PIXELS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_kind  (kind),
        .i_addr  (s_axis_tdata[51:32]),
        .i_first (s_axis_tdata[52]),
        .i_last  (s_axis_tdata[53]),
        .i_pal   (pal_rgb),
        .o_ready (s_axis_tready),
        .o_valid (sum_valid),
        .o_item  (sum_item),
        .i_ready (sum_ready)
    );

    gcfa_encode #(
        .FRAMES (FRAMES)
    ) u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .i_item  (sum_item),
        .o_ready (sum_ready),
        .o_valid (m_axis_tvalid),
        .o_addr  (out_addr),
        .o_rgb   (out_rgb),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, out_rgb.blue, out_rgb.green, out_rgb.red, out_addr};

endmodule

@@ sv/gcfa_palette.sv @@
// Palette memory: 256 RGB entries, one write port and one registered read port.
// Depends on gcfa_pkg for the entry type.
module gcfa_palette
    import gcfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [COLOR_W-1:0] i_waddr,
    input  t_rgb               i_wdata,
    input  logic               i_re,
    input  logic [COLOR_W-1:0] i_raddr,
    output t_rgb               o_rdata
);

    t_rgb mem [256];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/gcfa_accum.sv @@
// Per-pixel accumulator stage: memory read, linearisation, saturating add and write-back.
// Forwards the previous write when the next request hits the same pixel.
// Depends on gcfa_pkg for types, constants and the linearising table.
module gcfa_accum
    import gcfa_pkg::*;
#(
    parameter int unsigned PIXELS = DEF_PIXELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_first,
    input  logic              i_last,
    input  t_rgb              i_pal,
    output logic              o_ready,
    output logic              o_valid,
    output t_sum_item         o_item,
    input  logic              i_ready
);

    localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    t_sum3 mem [PIXELS];

    logic                 pix_ok;
    logic [AW+ADDR_W-1:0] addr_ext;
    logic [AW-1:0]        idx;
    logic                 s1_done;
    t_sum3                base;
    t_sum3                n_sum;

    logic              r_s1_valid;
    logic [AW-1:0]     r_s1_idx;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_first;
    logic              r_s1_last;
    t_sum3             r_rd_data;
    logic              r_fwd_valid;
    logic [AW-1:0]     r_fwd_idx;
    t_sum3             r_fwd_data;
    logic              r_s2_valid;
    t_sum_item         r_s2_item;

    function automatic t_ch_sum sat_add(input t_ch_sum b, input logic [COLOR_W-1:0] c);
        logic [CH_W:0] t;
        t = (CH_W+1)'(b) + (CH_W+1)'(LIN_TABLE[c]);
        return (t > (CH_W+1)'(CH_MAX)) ? CH_MAX : t[CH_W-1:0];
    endfunction

    assign pix_ok   = (i_kind == KIND_PIXEL) && (32'(i_addr) < PIXELS);
    assign addr_ext = (AW+ADDR_W)'(i_addr);
    assign idx      = addr_ext[AW-1:0];

    assign s1_done = r_s1_valid && (!r_s1_last || !r_s2_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_done;

    always_comb begin
        if (r_s1_first) begin
            base = '0;
        end else if (r_fwd_valid && (r_fwd_idx == r_s1_idx)) begin
            base = r_fwd_data;
        end else begin
            base = r_rd_data;
        end
        n_sum.red   = sat_add(base.red, i_pal.red);
        n_sum.green = sat_add(base.green, i_pal.green);
        n_sum.blue  = sat_add(base.blue, i_pal.blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_take && pix_ok) begin
            r_rd_data <= mem[idx];
        end
        if (s1_done) begin
            mem[r_s1_idx] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (i_take) begin
                r_s1_valid  <= pix_ok;
                r_fwd_valid <= s1_done;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done && r_s1_last) begin
                r_s2_valid <= 1'b1;
            end else if (i_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1_idx   <= idx;
            r_s1_addr  <= i_addr;
            r_s1_first <= i_first;
            r_s1_last  <= i_last;
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= n_sum;
        end
        if (s1_done && r_s1_last) begin
            r_s2_item.addr <= r_s1_addr;
            r_s2_item.sum  <= n_sum;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

    a_take_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && pix_ok) |=> r_s1_valid)
        else $error("accepted pixel request did not reach the accumulate stage");

    a_s1_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_done) |=> (r_s1_valid && $stable(r_s1_idx)))
        else $error("stalled accumulate stage lost its request");

    a_s2_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !i_ready) |=> (r_s2_valid && $stable(r_s2_item)))
        else $error("stalled sum stage changed before it was taken");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_s2_valid))
        else $error("pipeline not empty after reset");

endmodule

@@ sv/gcfa_encode.sv @@
// Averaging and gamma encoding: divides each channel sum by the frame count, clamps the
// quotient to LIN_MAX and looks it up in the gamma table. Depends on gcfa_pkg.
module gcfa_encode
    import gcfa_pkg::*;
#(
    parameter int unsigned FRAMES = DEF_FRAMES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_sum_item         i_item,
    output logic              o_ready,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_addr,
    output t_rgb              o_rgb,
    input  logic              i_ready
);

    localparam int unsigned DIV_SHIFT = CH_W + $clog2(FRAMES);
    localparam int unsigned MULT_W    = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = CH_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(FRAMES) - 64'd1) / 64'(FRAMES));

    logic s3_done;

    logic              r_s3_valid;
    logic [ADDR_W-1:0] r_s3_addr;
    logic [LIN_W-1:0]  r_q_red;
    logic [LIN_W-1:0]  r_q_green;
    logic [LIN_W-1:0]  r_q_blue;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_rgb              r_out_rgb;

    function automatic logic [LIN_W-1:0] average(input t_ch_sum s);
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   quo;
        prod = PROD_W'(s) * PROD_W'(DIV_MULT);
        quo  = prod[DIV_SHIFT +: CH_W];
        return (quo > CH_W'(LIN_MAX)) ? LIN_MAX : quo[LIN_W-1:0];
    endfunction

    assign s3_done = r_s3_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s3_valid || s3_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_s3_valid <= 1'b1;
            end else if (s3_done) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s3_addr <= i_item.addr;
            r_q_red   <= average(i_item.sum.red);
            r_q_green <= average(i_item.sum.green);
            r_q_blue  <= average(i_item.sum.blue);
        end
        if (s3_done) begin
            r_out_addr      <= r_s3_addr;
            r_out_rgb.red   <= GAM_TABLE[r_q_red];
            r_out_rgb.green <= GAM_TABLE[r_q_green];
            r_out_rgb.blue  <= GAM_TABLE[r_q_blue];
        end
    end

    assign o_valid = r_out_valid;
    assign o_addr  = r_out_addr;
    assign o_rgb   = r_out_rgb;

endmodule

@@ verif/tb_top.sv @@
// Testbench for gamma_correct_frame_averager_core: palette writes and multi-frame pixel
// sequences are streamed in at random rates, and every averaged pixel is checked against
// a prediction made inside the bench. Depends on gcfa_pkg and the core.
module tb_top;
    import gcfa_pkg::*;

    localparam int unsigned N_PIXELS     = DEF_PIXELS;
    localparam int unsigned N_FRAMES     = DEF_FRAMES;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned SLOTS        = 8;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [GAM_W-1:0]  red;
        logic [GAM_W-1:0]  green;
        logic [GAM_W-1:0]  blue;
    } t_averaged_pixel;

    class pixel_average_checker;
        logic [LIN_W-1:0] to_linear [256];
        logic [GAM_W-1:0] to_gamma [1024];
        t_rgb             palette [256];
        t_sum3            sums [int unsigned];
        t_averaged_pixel  expected_pixels [$];
        int unsigned      mismatches;

        function logic [191:0] power(input int unsigned base, input int unsigned ex);
            logic [191:0] p;
            p = 192'd1;
            repeat (ex) p = p * base;
            return p;
        endfunction

        // Both tables are exact truncations, found by integer comparison of powers.
        function new();
            logic [191:0] k255;
            logic [191:0] k1023;
            int unsigned  k;
            mismatches = 0;
            k255 = power(255, 11);
            k1023 = power(1023, 5);
            k = 0;
            for (int j = 0; j < 256; j++) begin
                while (k < 1023 && power(k + 1, 5) * k255 <= power(j, 11) * k1023) k++;
                to_linear[j] = LIN_W'(k);
            end
            k = 0;
            for (int j = 0; j < 1024; j++) begin
                while (k < 255 && power(k + 1, 11) * k1023 <= power(j, 5) * k255) k++;
                to_gamma[j] = GAM_W'(k);
            end
        endfunction

        function t_ch_sum add_linear(input t_ch_sum prev, input logic [COLOR_W-1:0] v);
            int unsigned s;
            s = prev + to_linear[v];
            return (s > CH_MAX) ? CH_MAX : t_ch_sum'(s);
        endfunction

        function logic [GAM_W-1:0] encode(input t_ch_sum s);
            int unsigned q;
            q = s / N_FRAMES;
            if (q > LIN_MAX) q = LIN_MAX;
            return to_gamma[q];
        endfunction

        function void note_request(input logic kind, input logic [COLOR_W-1:0] idx,
                                   input t_rgb colour, input logic [ADDR_W-1:0] addr,
                                   input logic first, input logic last);
            t_sum3           s;
            t_rgb            c;
            t_averaged_pixel px;
            if (kind == KIND_PALETTE) begin
                palette[idx] = colour;
                return;
            end
            if (addr >= N_PIXELS) return;
            c = palette[idx];
            s = first ? '0 : sums[addr];
            s.red = add_linear(s.red, c.red);
            s.green = add_linear(s.green, c.green);
            s.blue = add_linear(s.blue, c.blue);
            sums[addr] = s;
            if (last) begin
                px.addr = addr;
                px.red = encode(s.red);
                px.green = encode(s.green);
                px.blue = encode(s.blue);
                expected_pixels.push_back(px);
            end
        endfunction

        function void check_pixel(input logic [47:0] data);
            t_averaged_pixel got;
            t_averaged_pixel want;
            got.addr = data[19:0];
            got.red = data[27:20];
            got.green = data[35:28];
            got.blue = data[43:36];
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected averaged pixel: address %h rgb %h %h %h",
                             got.addr, got.red, got.green, got.blue);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.addr != want.addr || got.red != want.red || got.green != want.green
                    || got.blue != want.blue) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"averaged pixel mismatch: expected %h rgb %h %h %h, ",
                              "got %h rgb %h %h %h"},
                             want.addr, want.red, want.green, want.blue,
                             got.addr, got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    pixel_average_checker chk = new();
    bit                   pal_written [256];
    logic [COLOR_W-1:0]   bright_idx = 8'd200;
    int unsigned          send_run = 0;

    gamma_correct_frame_averager_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned draw_gap(ref int unsigned run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic send_request(input logic kind, input logic [COLOR_W-1:0] idx,
                                input t_rgb colour, input logic [ADDR_W-1:0] addr,
                                input logic first, input logic last);
        int unsigned gap;
        gap = draw_gap(send_run);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, last, first, addr, colour.blue, colour.green, colour.red, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        chk.note_request(kind, idx, colour, addr, first, last);
        if (kind == KIND_PALETTE) pal_written[idx] = 1'b1;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk.expected_pixels.size() != 0);
    endtask

    task automatic run_directed();
        send_request(KIND_PALETTE, 8'd0,   24'h000000, 20'h00000, 1'b0, 1'b0);
        send_request(KIND_PALETTE, 8'd255, 24'hFFFFFF, 20'hFFFFF, 1'b1, 1'b1);
        send_request(KIND_PALETTE, 8'd128, 24'h01FE80, 20'h00000, 1'b0, 1'b0);
        send_request(KIND_PALETTE, 8'd7,   24'hFF0000, 20'h00000, 1'b0, 1'b0);
        send_request(KIND_PALETTE, 8'd200, 24'hFFFFFF, 20'h00000, 1'b0, 1'b0);
        send_request(KIND_PIXEL,   8'd255, 24'h000000, 20'h00000, 1'b1, 1'b1);
        send_request(KIND_PIXEL,   8'd0,   24'hFFFFFF, 20'hFFFFF, 1'b1, 1'b1);
        send_request(KIND_PIXEL,   8'd128, 24'hFFFFFF, 20'hFFFFF, 1'b1, 1'b1);
        send_request(KIND_PIXEL,   8'd255, 24'h000000, 20'h00005, 1'b1, 1'b0);
        send_request(KIND_PIXEL,   8'd7,   24'h000000, 20'h00005, 1'b0, 1'b0);
        send_request(KIND_PIXEL,   8'd128, 24'h000000, 20'h00005, 1'b0, 1'b1);
        send_request(KIND_PIXEL,   8'd255, 24'h000000, 20'h00005, 1'b1, 1'b1);
        send_request(KIND_PALETTE, 8'd255, 24'h102030, 20'h00000, 1'b0, 1'b0);
        send_request(KIND_PIXEL,   8'd255, 24'h000000, 20'h00000, 1'b1, 1'b1);
        send_request(KIND_PIXEL,   8'd7,   24'h000000, 20'h00000, 1'b1, 1'b0);
        send_request(KIND_PIXEL,   8'd7,   24'h000000, 20'h00000, 1'b0, 1'b1);
    endtask

    // Most requests belong to well-formed frame sequences on a few pixels at a time;
    // the rest are restarts, early endings and palette rewrites.
    task automatic run_random();
        int unsigned        slot_addr [SLOTS];
        int unsigned        slot_frames [SLOTS];
        int unsigned        slot_len [SLOTS];
        bit                 slot_bright [SLOTS];
        int unsigned        slot;
        int unsigned        item;
        logic [COLOR_W-1:0] idx;
        logic               first;
        logic               last;
        t_rgb               colour;
        for (int i = 0; i < SLOTS; i++) slot_frames[i] = 0;
        slot = 0;
        item = 0;
        while (item < RANDOM_ITEMS) begin
            if (item == RANDOM_ITEMS / 2) wait_until_drained();
            colour = 24'($urandom());
            if ($urandom_range(0, 9) == 0) begin
                idx = 8'($urandom());
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) colour = 24'hFFFFFF;
                    else colour = {8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
                                   8'($urandom_range(240, 255))};
                    bright_idx = idx;
                end
                send_request(KIND_PALETTE, idx, colour, ADDR_W'($urandom()),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 2) != 0) slot = $urandom_range(0, SLOTS - 1);
                if (slot_frames[slot] == 0) begin
                    if ($urandom_range(0, 9) == 0)
                        slot_addr[slot] = ($urandom_range(0, 1) == 0) ? 0 : N_PIXELS - 1;
                    else
                        slot_addr[slot] = $urandom_range(0, N_PIXELS - 1);
                    slot_bright[slot] = ($urandom_range(0, 3) == 0);
                    if (slot_bright[slot]) slot_len[slot] = $urandom_range(N_FRAMES, 40);
                    else if ($urandom_range(0, 1) == 0) slot_len[slot] = N_FRAMES;
                    else slot_len[slot] = $urandom_range(1, 40);
                end
                if (slot_bright[slot]) idx = bright_idx;
                else do idx = 8'($urandom()); while (!pal_written[idx]);
                first = (slot_frames[slot] == 0) || ($urandom_range(0, 49) == 0);
                if (first) slot_frames[slot] = 0;
                slot_frames[slot]++;
                last = (slot_frames[slot] >= slot_len[slot]) || ($urandom_range(0, 49) == 0);
                send_request(KIND_PIXEL, idx, colour, ADDR_W'(slot_addr[slot]), first, last);
                if (last) slot_frames[slot] = 0;
            end
            item++;
        end
    endtask

    initial begin : drain_results
        int unsigned gap;
        int unsigned run_left;
        int unsigned taken;
        run_left = 0;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = (taken == 12) ? HOLD_CYCLES : draw_gap(run_left);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            chk.check_pixel(m_axis_tdata);
            taken++;
        end
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
            else idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.expected_pixels.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
